/* rtl/itoa_fmt_pkg.sv */
`default_nettype none

package itoa_fmt_pkg;

  localparam int MODE_W  = 3;
  localparam int VALUE_W = 64;
  localparam int CHAR_W  = 8;
  localparam int COUNT_W = 31;
  localparam int DIGIT_W = 4;
  localparam int PIDX_W  = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // floor(x / 10) == (x * RECIP10) >> RECIP10_SHIFT for any 32-bit x
  localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
  localparam int          RECIP10_SHIFT = 35;

  localparam logic [MODE_W-1:0] MODE_SDEC  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_UDEC  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HEXLO = 3'd2;
  localparam logic [MODE_W-1:0] MODE_HEXUP = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PTR   = 3'd4;

  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_MINUS,
    PRE_HEX,
    PRE_NIL
  } pre_kind_t;

  typedef enum logic [1:0] {
    CLS_IGNORE,
    CLS_DEC,
    CLS_HEX,
    CLS_NIL
  } in_class_t;

  typedef struct packed {
    logic load;
    logic dec_mul;
    logic dec_div;
    logic hex_step;
    logic emit_pre;
    logic emit_dig;
  } cmd_t;

  typedef struct packed {
    in_class_t in_class;
    logic      dec_last;
    logic      hex_last;
    logic      slot_free;
    logic      pre_empty;
    logic      pre_last;
    logic      pre_nil;
    logic      dig_last;
  } status_t;

  function automatic logic [PIDX_W-1:0] prefix_len(input pre_kind_t kind);
    case (kind)
      PRE_MINUS: return 3'd1;
      PRE_HEX:   return 3'd2;
      PRE_NIL:   return 3'd5;
      default:   return 3'd0;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] prefix_char(input pre_kind_t kind,
                                                    input logic [PIDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = "-";
    case (kind)
      PRE_HEX: c = (idx == 3'd0) ? "0" : "x";
      PRE_NIL: begin
        case (idx)
          3'd0:    c = "(";
          3'd1:    c = "n";
          3'd2:    c = "i";
          3'd3:    c = "l";
          default: c = ")";
        endcase
      end
      default: c = "-";
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
                                                   input logic upper);
    if (d < 4'd10) begin
      return 8'h30 + {4'd0, d};
    end else if (upper) begin
      return 8'h37 + {4'd0, d};
    end else begin
      return 8'h57 + {4'd0, d};
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/itoa_fmt_ifs.sv */
`default_nettype none

interface itoa_fmt_in_if;
  logic                               valid;
  logic                               ready;
  logic [itoa_fmt_pkg::MODE_W-1:0]    mode;
  logic [itoa_fmt_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface itoa_fmt_out_if;
  logic                               valid;
  logic                               ready;
  logic [itoa_fmt_pkg::CHAR_W-1:0]    char_out;
  logic                               is_last;
  logic [itoa_fmt_pkg::COUNT_W-1:0]   total_written;

  modport source (output valid, output char_out, output is_last, output total_written,
                  input ready);
  modport sink   (input valid, input char_out, input is_last, input total_written,
                  output ready);
endinterface

`default_nettype wire

/* rtl/itoa_fmt_dp.sv */
`default_nettype none

module itoa_fmt_dp #(
  parameter int MAX_DIGITS = 20
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire itoa_fmt_pkg::cmd_t                 cmd,
  output itoa_fmt_pkg::status_t                   sts,
  input  wire logic [itoa_fmt_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [itoa_fmt_pkg::VALUE_W-1:0]   in_value,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [itoa_fmt_pkg::CHAR_W-1:0]         char_out,
  output logic                                    is_last,
  output logic [itoa_fmt_pkg::COUNT_W-1:0]        total_written
);

  localparam int ND_W  = $clog2(MAX_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int QUO_W = 64 - itoa_fmt_pkg::RECIP10_SHIFT;

  logic [itoa_fmt_pkg::VALUE_W-1:0]  work_value;
  logic [63:0]                       prod;
  logic [itoa_fmt_pkg::DIGIT_W-1:0]  digit_store [MAX_DIGITS];
  logic [ND_W-1:0]                   nd;
  logic [itoa_fmt_pkg::PIDX_W-1:0]   pre_idx;
  itoa_fmt_pkg::pre_kind_t           pre_kind;
  logic                              upper;
  logic [itoa_fmt_pkg::COUNT_W-1:0]  char_count;

  // load decode
  logic [31:0]                       lo;
  logic [31:0]                       lo_neg;
  logic                              lo_is_neg;
  itoa_fmt_pkg::pre_kind_t           ld_kind;
  itoa_fmt_pkg::in_class_t           ld_class;
  logic [itoa_fmt_pkg::VALUE_W-1:0]  ld_value;

  // digit step
  logic [QUO_W-1:0]                  quo;
  logic [itoa_fmt_pkg::DIGIT_W-1:0]  q10_lo;
  logic [itoa_fmt_pkg::DIGIT_W-1:0]  dec_digit;
  logic                              nd_at_end;
  logic [IDX_W-1:0]                  wr_idx;
  logic [IDX_W-1:0]                  rd_idx;
  logic [ND_W-1:0]                   nd_less;
  logic                              emit;
  logic [itoa_fmt_pkg::COUNT_W-1:0]  count_next;

  // status
  logic                              dec_last;
  logic                              hex_last;
  logic                              slot_free;
  logic                              pre_empty;
  logic                              pre_last;
  logic                              pre_nil;
  logic                              dig_last;

  assign lo        = in_value[31:0];
  assign lo_neg    = (~lo) + 32'd1;
  assign lo_is_neg = (in_mode == itoa_fmt_pkg::MODE_SDEC) && lo[31];

  always_comb begin
    ld_kind  = itoa_fmt_pkg::PRE_NONE;
    ld_value = in_value;
    ld_class = itoa_fmt_pkg::CLS_IGNORE;
    case (in_mode)
      itoa_fmt_pkg::MODE_SDEC: begin
        ld_class = itoa_fmt_pkg::CLS_DEC;
        ld_value = {32'd0, lo_is_neg ? lo_neg : lo};
        if (lo_is_neg) begin
          ld_kind = itoa_fmt_pkg::PRE_MINUS;
        end
      end
      itoa_fmt_pkg::MODE_UDEC: begin
        ld_class = itoa_fmt_pkg::CLS_DEC;
        ld_value = {32'd0, lo};
      end
      itoa_fmt_pkg::MODE_HEXLO, itoa_fmt_pkg::MODE_HEXUP: begin
        ld_class = itoa_fmt_pkg::CLS_HEX;
      end
      itoa_fmt_pkg::MODE_PTR: begin
        if (in_value == '0) begin
          ld_class = itoa_fmt_pkg::CLS_NIL;
          ld_kind  = itoa_fmt_pkg::PRE_NIL;
        end else begin
          ld_class = itoa_fmt_pkg::CLS_HEX;
          ld_kind  = itoa_fmt_pkg::PRE_HEX;
        end
      end
      default: ld_class = itoa_fmt_pkg::CLS_IGNORE;
    endcase
  end

  // remainder only needs the low nibble of 10*q since it is below ten
  assign quo       = prod[63:itoa_fmt_pkg::RECIP10_SHIFT];
  assign q10_lo    = {quo[0], 3'b000} + {quo[2:0], 1'b0};
  assign dec_digit = work_value[3:0] - q10_lo;
  assign nd_at_end = (nd == ND_W'(MAX_DIGITS - 1));
  assign wr_idx    = nd[IDX_W-1:0];
  assign nd_less   = nd - ND_W'(1);
  assign rd_idx    = nd_less[IDX_W-1:0];

  assign emit       = cmd.emit_pre || cmd.emit_dig;
  assign count_next = (char_count == itoa_fmt_pkg::COUNT_MAX) ? char_count
                                                              : char_count + 1'b1;

  assign dec_last  = (quo == '0) || nd_at_end;
  assign hex_last  = (work_value[63:4] == '0) || nd_at_end;
  assign slot_free = !out_valid || out_ready;
  assign pre_empty = (itoa_fmt_pkg::prefix_len(pre_kind) == '0);
  assign pre_last  = (pre_idx == itoa_fmt_pkg::prefix_len(pre_kind) - 3'd1);
  assign pre_nil   = (pre_kind == itoa_fmt_pkg::PRE_NIL);
  assign dig_last  = (nd == ND_W'(1));

  assign sts = {ld_class, dec_last, hex_last, slot_free, pre_empty, pre_last, pre_nil,
                dig_last};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pre_kind   <= ld_kind;
      upper      <= (in_mode == itoa_fmt_pkg::MODE_HEXUP);
    end
    if (cmd.dec_mul) begin
      prod <= work_value[31:0] * itoa_fmt_pkg::RECIP10;
    end
    if (cmd.dec_div) begin
      digit_store[wr_idx] <= dec_digit;
    end
    if (cmd.hex_step) begin
      digit_store[wr_idx] <= work_value[3:0];
    end
    if (emit) begin
      total_written <= count_next;
      if (cmd.emit_pre) begin
        char_out <= itoa_fmt_pkg::prefix_char(pre_kind, pre_idx);
        is_last  <= pre_last && pre_nil;
      end else begin
        char_out <= itoa_fmt_pkg::digit_char(digit_store[rd_idx], upper);
        is_last  <= dig_last;
      end
    end
    if (rst) begin
      nd         <= '0;
      pre_idx    <= '0;
      char_count <= '0;
      out_valid  <= 1'b0;
      work_value <= '0;
    end else begin
      if (cmd.load) begin
        work_value <= ld_value;
      end else if (cmd.dec_div) begin
        work_value <= {{(64 - QUO_W){1'b0}}, quo};
      end else if (cmd.hex_step) begin
        work_value <= {4'd0, work_value[63:4]};
      end
      if (cmd.load) begin
        nd      <= '0;
        pre_idx <= '0;
      end else if (cmd.dec_div || cmd.hex_step) begin
        nd <= nd + ND_W'(1);
      end else if (cmd.emit_dig) begin
        nd <= nd_less;
      end
      if (cmd.emit_pre) begin
        pre_idx <= pre_idx + 3'd1;
      end
      if (emit) begin
        char_count <= count_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_emit_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_pre || cmd.emit_dig) |-> (!out_valid || out_ready))
    else $error("character issued while output register is occupied");

  a_nd_bound: assert property (@(posedge clk) disable iff (rst)
    nd <= ND_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_dig_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_dig |-> (nd != '0))
    else $error("digit read from empty store");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (total_written != '0))
    else $error("valid character with zero running count");

endmodule

`default_nettype wire

/* rtl/itoa_fmt_ctrl.sv */
`default_nettype none

module itoa_fmt_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire itoa_fmt_pkg::status_t sts,
  output itoa_fmt_pkg::cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_HEX,
    S_PRE,
    S_DIG
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load = 1'b1;
          case (sts.in_class)
            itoa_fmt_pkg::CLS_DEC: state_next = S_MUL;
            itoa_fmt_pkg::CLS_HEX: state_next = S_HEX;
            itoa_fmt_pkg::CLS_NIL: state_next = S_PRE;
            default:               state_next = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        cmd.dec_mul = 1'b1;
        state_next  = S_DIV;
      end
      S_DIV: begin
        cmd.dec_div = 1'b1;
        state_next  = sts.dec_last ? S_PRE : S_MUL;
      end
      S_HEX: begin
        cmd.hex_step = 1'b1;
        if (sts.hex_last) begin
          state_next = S_PRE;
        end
      end
      S_PRE: begin
        if (sts.pre_empty) begin
          state_next = S_DIG;
        end else if (sts.slot_free) begin
          cmd.emit_pre = 1'b1;
          if (sts.pre_last) begin
            state_next = sts.pre_nil ? S_IDLE : S_DIG;
          end
        end
      end
      S_DIG: begin
        if (sts.slot_free) begin
          cmd.emit_dig = 1'b1;
          if (sts.dig_last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/integer_to_ascii_formatter_unit.sv */
// Integer-to-ASCII formatter.
// in_ch carries mode and value; out_ch returns one ASCII character per
// transfer, most significant first, with is_last on the final character
// and total_written holding the saturating running character count.
// An item is taken only in the idle state. Digits come from a shared
// extraction unit: hex takes one digit per nibble shift, decimal one
// digit per reciprocal multiply, then quotient/remainder step. Each
// character then passes through the output register.
// An item goes through load, digit extraction, prefix characters and
// then digits; "(nil)" skips extraction. Modes 5 to 7 are taken and
// give no characters.
// After the last extraction step, the first character is registered in
// the prefix state, or, when there is no prefix, in the digit state
// that follows it.
// When out_ch stalls, the held character stays in the output register and
// the sequencer waits; the next item is taken once the last character has
// been placed there, even if it has not yet been transferred.
// Reset (synchronous) clears the sequencer, the output valid and the count;
// in_ch is not ready while rst is high.
`default_nettype none

module integer_to_ascii_formatter_unit #(
  parameter int MAX_DIGITS = 20
) (
  input wire logic        clk,
  input wire logic        rst,
  itoa_fmt_in_if.sink     in_ch,
  itoa_fmt_out_if.source  out_ch
);

  itoa_fmt_pkg::cmd_t    cmd;
  itoa_fmt_pkg::status_t sts;

  itoa_fmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  itoa_fmt_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (in_ch.mode),
    .in_value      (in_ch.value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .char_out      (out_ch.char_out),
    .is_last       (out_ch.is_last),
    .total_written (out_ch.total_written)
  );

endmodule

`default_nettype wire
